@@ design/tbet_pkg.sv @@
// ----------------------------------------------------------------------------
// tbet_pkg: shared types and constants of the timestamped bit-event trace
// Request and response payloads, the decoded command that flows from the
// front end to the back end, and the trace store sizing.
// ----------------------------------------------------------------------------
package tbet_pkg;

	localparam int TRACE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TRACE_DEPTH);
	localparam int POS_W       = $clog2(TRACE_DEPTH + 1);
	localparam int TIME_W      = 56;
	localparam int WORD_W      = 32;
	localparam int INDEX_W     = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Request mode codes
	localparam logic [1:0] MODE_TICK       = 2'd0;
	localparam logic [1:0] MODE_MARK       = 2'd1;
	localparam logic [1:0] MODE_READ_ENTRY = 2'd2;
	localparam logic [1:0] MODE_READ_TIME  = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic               set_enable;
		logic [4:0]         set_index;
		logic               clear_enable;
		logic [4:0]         clear_index;
		logic               toggle_enable;
		logic [4:0]         toggle_index;
		logic [INDEX_W-1:0] read_index;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [WORD_W-1:0] entry_time;
		logic [WORD_W-1:0] entry_flags;
		logic [TIME_W-1:0] now_time;
	} rsp_t;

	// Decoded operation
	typedef enum logic [2:0] {
		OP_TICK,
		OP_MARK,
		OP_RESTART,
		OP_READ_ENTRY,
		OP_READ_TIME
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [WORD_W-1:0]  set_mask;
		logic [WORD_W-1:0]  clear_mask;
		logic [WORD_W-1:0]  toggle_mask;
		logic [INDEX_W-1:0] read_index;
	} cmd_t;

endpackage

@@ design/tbet_front.sv @@
// ----------------------------------------------------------------------------
// tbet_front: request classifier
// Turns each request into a command: picks the operation and expands the
// flag edit indexes into bit masks, disabled edits giving an empty mask.
// ----------------------------------------------------------------------------
module tbet_front (
	input  tbet_pkg::req_t req,
	output tbet_pkg::cmd_t cmd
);

	logic any_edit;

	assign any_edit = req.set_enable | req.clear_enable | req.toggle_enable;

	// Classify the request
	always_comb begin
		cmd = '0;
		unique case (req.mode)
			tbet_pkg::MODE_TICK: begin
				cmd.op = tbet_pkg::OP_TICK;
			end
			tbet_pkg::MODE_MARK: begin
				cmd.op = any_edit ? tbet_pkg::OP_MARK : tbet_pkg::OP_RESTART;
			end
			tbet_pkg::MODE_READ_ENTRY: begin
				cmd.op = tbet_pkg::OP_READ_ENTRY;
			end
			default: begin
				cmd.op = tbet_pkg::OP_READ_TIME;
			end
		endcase
		// Expand edit indexes into one-hot masks
		if (req.set_enable) begin
			cmd.set_mask = tbet_pkg::WORD_W'(1) << req.set_index;
		end
		if (req.clear_enable) begin
			cmd.clear_mask = tbet_pkg::WORD_W'(1) << req.clear_index;
		end
		if (req.toggle_enable) begin
			cmd.toggle_mask = tbet_pkg::WORD_W'(1) << req.toggle_index;
		end
		cmd.read_index = req.read_index;
	end

endmodule

@@ design/tbet_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// tbet_cmd_fifo: command queue between front and back end
// A small first-in first-out buffer of decoded commands so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module tbet_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tbet_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output tbet_pkg::cmd_t head_cmd,
	output logic           empty
);

	tbet_pkg::cmd_t                    slot_q [tbet_pkg::QUEUE_DEPTH];
	logic [tbet_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [tbet_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [tbet_pkg::QCNT_W-1:0]       count_q;

	assign full     = (count_q == tbet_pkg::QCNT_W'(tbet_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = slot_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/tbet_back.sv @@
// ----------------------------------------------------------------------------
// tbet_back: command execution
// Holds the time counter, trace start, flag word, write position and trace
// store. Ticks and marks finish in the cycle they leave the queue; reads go
// via a read stage (registered store read for entries) and response register.
// ----------------------------------------------------------------------------
module tbet_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  tbet_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tbet_pkg::rsp_t rsp
);

	logic [tbet_pkg::TIME_W-1:0] time_q;
	logic [tbet_pkg::TIME_W-1:0] start_q;
	logic [tbet_pkg::WORD_W-1:0] flags_q;
	logic [tbet_pkg::POS_W-1:0]  wpos_q;

	logic [2*tbet_pkg::WORD_W-1:0] store_q [tbet_pkg::TRACE_DEPTH];
	logic [2*tbet_pkg::WORD_W-1:0] rd_data_q;

	// Read stage: waits for the store read data
	logic                        valid_s1;
	logic                        entry_s1;
	logic                        found_s1;
	logic [tbet_pkg::TIME_W-1:0] now_s1;

	logic                        out_valid_q;
	tbet_pkg::rsp_t              out_q;

	logic                        is_read;
	logic                        advance_s1;
	logic                        do_mark;
	logic [tbet_pkg::WORD_W-1:0] new_flags;
	logic [tbet_pkg::TIME_W-1:0] rel_time;
	logic [tbet_pkg::POS_W-1:0]  read_pos;

	assign is_read    = (cmd.op == tbet_pkg::OP_READ_ENTRY) ||
	                    (cmd.op == tbet_pkg::OP_READ_TIME);
	assign advance_s1 = valid_s1 && (!out_valid_q || rsp_ready);
	// Hold reads while the read stage is blocked
	assign cmd_pop    = cmd_valid && (!is_read || !valid_s1 || advance_s1);
	assign do_mark    = cmd_pop && (cmd.op == tbet_pkg::OP_MARK) &&
	                    (wpos_q != tbet_pkg::POS_W'(tbet_pkg::TRACE_DEPTH));
	assign new_flags  = ((flags_q | cmd.set_mask) & ~cmd.clear_mask) ^ cmd.toggle_mask;
	assign rel_time   = time_q - start_q;
	assign read_pos   = tbet_pkg::POS_W'(cmd.read_index);

	assign rsp_valid  = out_valid_q;
	assign rsp        = out_q;

	// Trace store write and registered read
	always_ff @(posedge clk) begin
		if (do_mark) begin
			store_q[wpos_q[tbet_pkg::ADDR_W-1:0]] <=
				{rel_time[tbet_pkg::WORD_W-1:0], new_flags};
		end
		if (cmd_pop && (cmd.op == tbet_pkg::OP_READ_ENTRY)) begin
			rd_data_q <= store_q[cmd.read_index[tbet_pkg::ADDR_W-1:0]];
		end
	end

	// Update time, trace start, flags and write position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			start_q <= '0;
			flags_q <= '0;
			wpos_q  <= '0;
		end else if (cmd_pop) begin
			unique case (cmd.op)
				tbet_pkg::OP_TICK: begin
					time_q <= time_q + 1'b1;
				end
				tbet_pkg::OP_RESTART: begin
					start_q <= time_q;
					flags_q <= '0;
					wpos_q  <= '0;
				end
				tbet_pkg::OP_MARK: begin
					if (do_mark) begin
						flags_q <= new_flags;
						wpos_q  <= wpos_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Read stage payload
	always_ff @(posedge clk) begin
		if (cmd_pop && is_read) begin
			entry_s1 <= (cmd.op == tbet_pkg::OP_READ_ENTRY);
			found_s1 <= (cmd.op == tbet_pkg::OP_READ_ENTRY) && (read_pos < wpos_q);
			now_s1   <= time_q;
		end
	end

	// Read stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_pop && is_read) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Build the response
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			out_q.found       <= found_s1;
			out_q.entry_time  <= found_s1 ?
				rd_data_q[2*tbet_pkg::WORD_W-1:tbet_pkg::WORD_W] : '0;
			out_q.entry_flags <= found_s1 ? rd_data_q[tbet_pkg::WORD_W-1:0] : '0;
			out_q.now_time    <= entry_s1 ? '0 : now_s1;
		end
	end

	// Response register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ design/timestamped_bit_event_trace.sv @@
// ----------------------------------------------------------------------------
// timestamped_bit_event_trace: timestamped bit-event trace buffer
// Tick-driven 56-bit time counter, 32-bit flag word and a 1024-entry trace
// of (relative time, flag word) records with read-back.
// ----------------------------------------------------------------------------
// A request is taken every cycle while the four-entry command queue has room.
// Ticks and marks complete in the cycle they leave the queue, so they sustain
// one request per cycle. A read of a trace entry or of the current time
// passes through the read stage (the trace store's registered read port for
// entries) and then the response register, and back-to-back reads also
// sustain one per cycle while responses are taken.
// The trace store needs no clearing after reset: only entries below the
// write position are ever returned.
module timestamped_bit_event_trace (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tbet_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tbet_pkg::rsp_t rsp
);

	tbet_pkg::cmd_t dec_cmd;
	tbet_pkg::cmd_t head_cmd;
	logic           queue_full;
	logic           queue_empty;
	logic           cmd_pop;

	assign req_ready = !queue_full;

	// Classify requests
	tbet_front u_front (
		.req (req),
		.cmd (dec_cmd)
	);

	// Queue decoded commands
	tbet_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (req_valid && req_ready),
		.push_cmd (dec_cmd),
		.full     (queue_full),
		.pop      (cmd_pop),
		.head_cmd (head_cmd),
		.empty    (queue_empty)
	);

	// Execute commands
	tbet_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!queue_empty),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
